/* hdl/glos_pkg.sv */
// shared types and constants for the grid line-of-sight unit
// no dependencies
package glos_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;
    localparam int COORD_W         = 6;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic wr;
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic at_end;
        logic blocked;
    } status_t;

endpackage

/* hdl/glos_req_if.sv */
// request channel: map writes and line-of-sight queries
// depends on glos_pkg
interface glos_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [glos_pkg::COORD_W-1:0] start_x;
    logic [glos_pkg::COORD_W-1:0] start_y;
    logic [glos_pkg::COORD_W-1:0] end_x;
    logic [glos_pkg::COORD_W-1:0] end_y;
    logic                        see_through;

    modport source (
        output valid, req_type, start_x, start_y, end_x, end_y, see_through,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, start_y, end_x, end_y, see_through,
        output ready
    );
endinterface

/* hdl/glos_rsp_if.sv */
// response channel: one visibility bit per query
// no dependencies
interface glos_rsp_if;
    logic valid;
    logic ready;
    logic is_visible;

    modport source (
        output valid, is_visible,
        input  ready
    );
    modport sink (
        input  valid, is_visible,
        output ready
    );
endinterface

/* hdl/glos_ctrl.sv */
// controller: accepts transactions, sequences the line walk, holds the result register
// depends on glos_pkg
module glos_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_type,
    output logic              req_ready,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic              rsp_is_visible,
    input  glos_pkg::status_t status,
    output glos_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_vis_reg;
    logic   accept;
    logic   finishing;
    logic   slot_free;

    always_comb
    begin
        req_ready = (state_reg == ST_IDLE);
        accept    = req_valid && req_ready;
        finishing = (state_reg == ST_WALK) && (status.blocked || status.at_end);
        slot_free = !rsp_valid_reg || rsp_ready;

        cmd.wr     = accept && (req_type == glos_pkg::REQ_WRITE);
        cmd.load   = accept && (req_type == glos_pkg::REQ_QUERY);
        cmd.finish = finishing && slot_free;
        cmd.step   = (state_reg == ST_WALK) && !finishing;

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_vis_reg <= !status.blocked;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign rsp_is_visible = rsp_vis_reg;

endmodule

/* hdl/glos_datapath.sv */
// datapath: opacity map memory, coordinate clamping and the bresenham error-term stepper
// depends on glos_pkg
module glos_datapath #(
    parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  glos_pkg::cmd_t               cmd,
    input  logic [glos_pkg::COORD_W-1:0] start_x,
    input  logic [glos_pkg::COORD_W-1:0] start_y,
    input  logic [glos_pkg::COORD_W-1:0] end_x,
    input  logic [glos_pkg::COORD_W-1:0] end_y,
    input  logic                         see_through,
    output glos_pkg::status_t            status
);

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int MW    = (XW > YW) ? XW : YW;
    localparam int EW    = MW + 3;
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [XW-1:0]        in_sx;
    logic [YW-1:0]        in_sy;
    logic [XW-1:0]        in_ex;
    logic [YW-1:0]        in_ey;
    logic signed [EW-1:0] diff_x;
    logic signed [EW-1:0] diff_y;
    logic signed [EW-1:0] abs_x;
    logic signed [EW-1:0] abs_y;

    logic [XW-1:0]        cur_x_reg;
    logic [YW-1:0]        cur_y_reg;
    logic [XW-1:0]        end_x_reg;
    logic [YW-1:0]        end_y_reg;
    logic signed [EW-1:0] dx_reg;
    logic signed [EW-1:0] dy_reg;
    logic signed [EW-1:0] err_reg;
    logic                 neg_x_reg;
    logic                 neg_y_reg;
    logic                 rd_valid_reg;
    logic                 rd_valid_next;
    logic                 rd_data_reg;

    logic signed [EW-1:0] e2;
    logic                 move_x;
    logic                 move_y;
    logic signed [EW-1:0] err_next;
    logic [XW-1:0]        nx;
    logic [YW-1:0]        ny;
    logic                 next_at_end;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;

    logic map_mem [DEPTH];

    always_comb
    begin
        in_sx = (32'(start_x) >= GRID_WIDTH)  ? XW'(GRID_WIDTH - 1)  : XW'(start_x);
        in_sy = (32'(start_y) >= GRID_HEIGHT) ? YW'(GRID_HEIGHT - 1) : YW'(start_y);
        in_ex = (32'(end_x) >= GRID_WIDTH)    ? XW'(GRID_WIDTH - 1)  : XW'(end_x);
        in_ey = (32'(end_y) >= GRID_HEIGHT)   ? YW'(GRID_HEIGHT - 1) : YW'(end_y);

        diff_x = signed'(EW'(in_ex)) - signed'(EW'(in_sx));
        diff_y = signed'(EW'(in_ey)) - signed'(EW'(in_sy));
        abs_x  = (diff_x < 0) ? -diff_x : diff_x;
        abs_y  = (diff_y < 0) ? -diff_y : diff_y;

        wr_addr = AW'(AW'(in_sy) * AW'(GRID_WIDTH)) + AW'(in_sx);

        e2       = err_reg <<< 1;
        move_x   = (e2 >= dy_reg);
        move_y   = (e2 <= dx_reg);
        err_next = err_reg + (move_x ? dy_reg : '0) + (move_y ? dx_reg : '0);
        nx = cur_x_reg;
        if (move_x)
        begin
            nx = neg_x_reg ? (cur_x_reg - XW'(1)) : (cur_x_reg + XW'(1));
        end
        ny = cur_y_reg;
        if (move_y)
        begin
            ny = neg_y_reg ? (cur_y_reg - YW'(1)) : (cur_y_reg + YW'(1));
        end
        next_at_end = (nx == end_x_reg) && (ny == end_y_reg);
        rd_addr     = AW'(AW'(ny) * AW'(GRID_WIDTH)) + AW'(nx);
        rd_en       = cmd.step && !next_at_end;

        rd_valid_next = rd_valid_reg;
        if (cmd.load)
        begin
            rd_valid_next = 1'b0;
        end
        else if (cmd.step)
        begin
            rd_valid_next = !next_at_end;
        end

        status.at_end  = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
        status.blocked = rd_valid_reg && rd_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg <= in_sx;
            cur_y_reg <= in_sy;
            end_x_reg <= in_ex;
            end_y_reg <= in_ey;
            dx_reg    <= abs_x;
            dy_reg    <= -abs_y;
            err_reg   <= abs_x - abs_y;
            neg_x_reg <= !(in_sx < in_ex);
            neg_y_reg <= !(in_sy < in_ey);
        end
        else if (cmd.step)
        begin
            cur_x_reg <= nx;
            cur_y_reg <= ny;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            map_mem[wr_addr] <= !see_through;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

endmodule

/* hdl/grid_line_of_sight_unit.sv */
// Line-of-sight unit over a one-bit opacity map. A write transaction returns nothing. A
// query walks the Bresenham line one cell per cycle through the map's single read port.
// A query holds the input until its walk finishes; an opaque cell can end the walk early,
// and a previous result that still waits in the output register delays the finish.
// The visibility bit is loaded into the output register at the edge that ends the walk,
// and it is offered in the same cycle that the input is ready again. Coordinates beyond
// the grid saturate to its last column or row. The map has no reset; every cell a query
// crosses must have been written first.
// depends on glos_pkg, glos_req_if, glos_rsp_if, glos_ctrl, glos_datapath
module grid_line_of_sight_unit #(
    parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    glos_req_if.sink   req,
    glos_rsp_if.source rsp
);

    glos_pkg::cmd_t    cmd;
    glos_pkg::status_t status;

    glos_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req.valid),
        .req_type       (req.req_type),
        .req_ready      (req.ready),
        .rsp_ready      (rsp.ready),
        .rsp_valid      (rsp.valid),
        .rsp_is_visible (rsp.is_visible),
        .status         (status),
        .cmd            (cmd)
    );

    glos_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .start_x     (req.start_x),
        .start_y     (req.start_y),
        .end_x       (req.end_x),
        .end_y       (req.end_y),
        .see_through (req.see_through),
        .status      (status)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) cmd.step |-> !req.ready)
        else $error("input accepted during a walk");
    assert property (@(posedge clk) disable iff (!rst_n) status.blocked |-> !cmd.step)
        else $error("walk stepped past an opaque cell");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (status.blocked || status.at_end))
        else $error("query finished before reaching an opaque cell or the end");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (rsp.valid && (rsp.is_visible == !$past(status.blocked))))
        else $error("result register does not match the finished walk");
`endif

endmodule
